### hw/rtl/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every clock, disabled during reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

### hw/rtl/xxh_pkg.sv
// Package: XXH64 constants, datapath command and status types.
package xxh_pkg;
  localparam logic [63:0] PR1 = 64'd11400714785074694791;
  localparam logic [63:0] PR2 = 64'd14029467366897019727;
  localparam logic [63:0] PR3 = 64'd1609587929392839161;
  localparam logic [63:0] PR4 = 64'd9650029242287828579;
  localparam logic [63:0] PR5 = 64'd2870177450012600261;

  // Datapath micro-operations.
  typedef enum logic [3:0] {
    OP_NONE    = 4'd0,
    OP_CAPTURE = 4'd1,  // latch word, count, last; update length
    OP_PUSH    = 4'd2,  // store word into pending buffer
    OP_FOLD_A  = 4'd3,  // lane: acc += w*PR2 (mul stage)
    OP_FOLD_B  = 4'd4,  // lane: rotl31, *PR1
    OP_INIT    = 4'd5,  // h = merge start or seed+PR5
    OP_MRG_A   = 4'd6,  // t = lane[i]*PR2
    OP_MRG_B   = 4'd7,  // h ^= rotl(t,31)*PR1
    OP_MRG_C   = 4'd8,  // h = h*PR1+PR4
    OP_LEN     = 4'd9,  // h += length
    OP_T_A     = 4'd10, // tail step first multiply
    OP_T_B     = 4'd11, // tail step second multiply
    OP_T_C     = 4'd12, // tail step third multiply
    OP_AV_A    = 4'd13, // avalanche multiply 1
    OP_AV_B    = 4'd14, // avalanche multiply 2
    OP_AV_C    = 4'd15  // final xor shift, publish
  } dp_op_t;

  typedef enum logic [1:0] {
    TK_WORD = 2'd0,
    TK_HALF = 2'd1,
    TK_BYTE = 2'd2
  } tail_kind_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] idx;   // lane / pending index
    tail_kind_t tk;
    logic [2:0] pos;   // byte position of a byte round
    logic       tsrc;  // tail operand: 1 = captured word, 0 = pending
  } dp_cmd_t;

  typedef struct packed {
    logic       last;
    logic [3:0] n;      // saturated byte count
    logic [1:0] pend;   // pending count
    logic       seen;   // stripe folded
    logic       mdone;  // multiply op completes this cycle
  } dp_sts_t;

  function automatic logic [63:0] rotl(input logic [63:0] x, input int r);
    rotl = (x << r) | (x >> (64 - r));
  endfunction
endpackage

### hw/rtl/xxh_stream_if.sv
// Valid/ready channel interfaces for words, digests and seed writes.
interface xxh_word_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_word;
  logic [3:0]  byte_count;
  logic        last_word;
  modport source (output valid, data_word, byte_count, last_word, input ready);
  modport sink (input valid, data_word, byte_count, last_word, output ready);
endinterface

interface xxh_hash_if;
  logic        valid;
  logic        ready;
  logic [63:0] hash_value;
  modport source (output valid, hash_value, input ready);
  modport sink (input valid, hash_value, output ready);
endinterface

interface xxh_cfg_if;
  logic        valid;
  logic        ready;
  logic [63:0] hash_seed;
  modport source (output valid, hash_seed, input ready);
  modport sink (input valid, hash_seed, output ready);
endinterface

### hw/rtl/xxhash64_stream_hasher.sv
// Top level of the XXH64 stream hasher.
// Channel  | Dir | Payload                                | Transfer
// word_in  | in  | data_word[63:0] byte_count[3:0] last_word | valid & ready
// hash_out | out | hash_value[63:0]                        | valid & ready
// seed_cfg | in  | hash_seed[63:0]                         | valid & ready
// Every 64-bit multiply runs on one shared 32x32 multiplier.
// A non-final word is captured and held; a word that completes a 32-byte
// stripe is folded instead (four lanes, two multiplies each).
// A final word adds an init step, four merge rounds when a stripe was folded,
// a length step, a round per held word, a round for a full last word or the
// 4-byte round plus a round per single byte, the stage steps and the avalanche.
// Reset is synchronous; no clearing pass. A new word waits while a digest
// is held undelivered; the seed port is always ready.
module xxhash64_stream_hasher (
  input  logic       clk,
  input  logic       rst,
  xxh_word_if.sink   word_in,
  xxh_hash_if.source hash_out,
  xxh_cfg_if.sink    seed_cfg
);
  logic [63:0]      seed;
  xxh_pkg::dp_cmd_t cmd;
  xxh_pkg::dp_sts_t sts;

  // Seed register; a write transfer is taken in any cycle.
  assign seed_cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) seed <= '0;
    else if (seed_cfg.valid) seed <= seed_cfg.hash_seed;
  end

  xxh_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (word_in.valid),
    .in_ready  (word_in.ready),
    .out_valid (hash_out.valid),
    .out_ready (hash_out.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  xxh_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_word  (word_in.data_word),
    .in_count (word_in.byte_count),
    .in_last  (word_in.last_word),
    .seed     (seed),
    .cmd      (cmd),
    .sts      (sts),
    .digest   (hash_out.hash_value)
  );
endmodule

### hw/rtl/xxh_datapath.sv
// XXH64 datapath: lanes, pending buffer, length, shared multiplier.
module xxh_datapath (
  input  logic               clk,
  input  logic               rst,
  input  logic [63:0]        in_word,
  input  logic [3:0]         in_count,
  input  logic               in_last,
  input  logic [63:0]        seed,
  input  xxh_pkg::dp_cmd_t   cmd,
  output xxh_pkg::dp_sts_t   sts,
  output logic [63:0]        digest
);
  logic [63:0] lane [4];
  logic [63:0] pend [3];
  logic [1:0]  pcnt;
  logic [63:0] len;
  logic        seen;
  logic [63:0] wreg;
  logic [3:0]  nreg;
  logic        lreg;
  logic [63:0] h;
  logic [63:0] t;
  logic [3:0]  nsat;
  logic [63:0] mul_a, mul_b, prod;
  logic [63:0] lane_cur, tail_op;
  logic        mul_op;
  logic        mdone;
  logic [1:0]  mph;     // multiply phase
  logic [31:0] mx, my;
  logic [63:0] m32;
  logic [63:0] pacc;    // partial product

  assign nsat = (!in_last || in_count > 4'd8) ? 4'd8 : in_count;
  assign lane_cur = (!seen && cmd.op == xxh_pkg::OP_FOLD_A) ?
    ((cmd.idx == 2'd0) ? seed + xxh_pkg::PR1 + xxh_pkg::PR2 :
     (cmd.idx == 2'd1) ? seed + xxh_pkg::PR2 :
     (cmd.idx == 2'd2) ? seed : seed - xxh_pkg::PR1) : lane[cmd.idx];
  assign tail_op = cmd.tsrc ? wreg : pend[cmd.idx];

  assign mul_op = cmd.op inside {xxh_pkg::OP_FOLD_A, xxh_pkg::OP_FOLD_B,
                                 xxh_pkg::OP_MRG_A, xxh_pkg::OP_MRG_B,
                                 xxh_pkg::OP_MRG_C, xxh_pkg::OP_T_A,
                                 xxh_pkg::OP_T_B, xxh_pkg::OP_T_C,
                                 xxh_pkg::OP_AV_A, xxh_pkg::OP_AV_B};

  // Operand select for the shared multiply.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      xxh_pkg::OP_FOLD_A: begin
        mul_a = (cmd.idx == 2'd3) ? wreg : pend[cmd.idx];
        mul_b = xxh_pkg::PR2;
      end
      xxh_pkg::OP_FOLD_B: begin
        mul_a = xxh_pkg::rotl(t, 31);
        mul_b = xxh_pkg::PR1;
      end
      xxh_pkg::OP_MRG_A: begin
        mul_a = lane[cmd.idx];
        mul_b = xxh_pkg::PR2;
      end
      xxh_pkg::OP_MRG_B: begin
        mul_a = xxh_pkg::rotl(t, 31);
        mul_b = xxh_pkg::PR1;
      end
      xxh_pkg::OP_MRG_C: begin
        mul_a = h;
        mul_b = xxh_pkg::PR1;
      end
      xxh_pkg::OP_T_A: begin
        case (cmd.tk)
          xxh_pkg::TK_WORD: begin
            mul_a = tail_op;
            mul_b = xxh_pkg::PR2;
          end
          xxh_pkg::TK_HALF: begin
            mul_a = {32'd0, wreg[31:0]};
            mul_b = xxh_pkg::PR1;
          end
          default: begin
            mul_a = {56'd0, wreg[8*cmd.pos +: 8]};
            mul_b = xxh_pkg::PR5;
          end
        endcase
      end
      xxh_pkg::OP_T_B: begin
        case (cmd.tk)
          xxh_pkg::TK_WORD: begin
            mul_a = xxh_pkg::rotl(t, 31);
            mul_b = xxh_pkg::PR1;
          end
          xxh_pkg::TK_HALF: begin
            mul_a = xxh_pkg::rotl(h, 23);
            mul_b = xxh_pkg::PR2;
          end
          default: begin
            mul_a = xxh_pkg::rotl(h, 11);
            mul_b = xxh_pkg::PR1;
          end
        endcase
      end
      xxh_pkg::OP_T_C: begin
        mul_a = xxh_pkg::rotl(h, 27);
        mul_b = xxh_pkg::PR1;
      end
      xxh_pkg::OP_AV_A: begin
        mul_a = h ^ (h >> 33);
        mul_b = xxh_pkg::PR2;
      end
      xxh_pkg::OP_AV_B: begin
        mul_a = h ^ (h >> 29);
        mul_b = xxh_pkg::PR3;
      end
      default: ;
    endcase
  end

  // One 32x32 multiplier builds the 64-bit low product from its parts:
  // lo*lo, lo*hi cross term, hi*lo cross term, then the result is held.
  always_comb begin
    case (mph)
      2'd0: begin
        mx = mul_a[31:0];
        my = mul_b[31:0];
      end
      2'd1: begin
        mx = mul_a[31:0];
        my = mul_b[63:32];
      end
      default: begin
        mx = mul_a[63:32];
        my = mul_b[31:0];
      end
    endcase
  end
  assign m32   = 64'(mx) * 64'(my);
  assign prod  = pacc;
  assign mdone = (mph == 2'd3);

  always_ff @(posedge clk) begin
    if (rst) begin
      pcnt <= '0;
      len  <= '0;
      seen <= 1'b0;
      mph  <= '0;
    end else begin
      mph <= mul_op ? mph + 2'd1 : 2'd0;
      case (mph)
        2'd0: pacc <= m32;
        2'd1, 2'd2: pacc <= pacc + {m32[31:0], 32'd0};
        default: ;
      endcase
      case (cmd.op)
        xxh_pkg::OP_CAPTURE: begin
          wreg <= in_word;
          nreg <= nsat;
          lreg <= in_last;
          len  <= len + {60'd0, nsat};
        end
        xxh_pkg::OP_PUSH: begin
          pend[pcnt] <= wreg;
          pcnt <= pcnt + 2'd1;
        end
        xxh_pkg::OP_FOLD_A: if (mdone) t <= lane_cur + prod;
        xxh_pkg::OP_FOLD_B: begin
          if (mdone) begin
            lane[cmd.idx] <= prod;
            if (cmd.idx == 2'd3) begin
              seen <= 1'b1;
              pcnt <= '0;
            end
          end
        end
        xxh_pkg::OP_INIT: begin
          h <= seen ? xxh_pkg::rotl(lane[0], 1) + xxh_pkg::rotl(lane[1], 7) +
                      xxh_pkg::rotl(lane[2], 12) + xxh_pkg::rotl(lane[3], 18)
                    : seed + xxh_pkg::PR5;
        end
        xxh_pkg::OP_MRG_A: if (mdone) t <= prod;
        xxh_pkg::OP_MRG_B: if (mdone) h <= h ^ prod;
        xxh_pkg::OP_MRG_C: if (mdone) h <= prod + xxh_pkg::PR4;
        xxh_pkg::OP_LEN: h <= h + len;
        xxh_pkg::OP_T_A: begin
          if (mdone) begin
            if (cmd.tk == xxh_pkg::TK_WORD) t <= prod;
            else h <= h ^ prod;
          end
        end
        xxh_pkg::OP_T_B: begin
          if (mdone) begin
            case (cmd.tk)
              xxh_pkg::TK_WORD: h <= h ^ prod;
              xxh_pkg::TK_HALF: h <= prod + xxh_pkg::PR3;
              default: h <= prod;
            endcase
          end
        end
        xxh_pkg::OP_T_C: if (mdone) h <= prod + xxh_pkg::PR4;
        xxh_pkg::OP_AV_A: if (mdone) h <= prod;
        xxh_pkg::OP_AV_B: if (mdone) h <= prod;
        xxh_pkg::OP_AV_C: begin
          digest <= h ^ (h >> 32);
          pcnt <= '0;
          len  <= '0;
          seen <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  assign sts = '{last: lreg, n: nreg, pend: pcnt, seen: seen, mdone: mdone};
endmodule

### hw/rtl/xxh_ctrl.sv
// XXH64 sequencer: steps the datapath through fold, merge, tail, avalanche.
module xxh_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  xxh_pkg::dp_sts_t sts,
  output xxh_pkg::dp_cmd_t cmd
);
  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_DEC  = 10'b0000000010,
    S_FA   = 10'b0000000100,
    S_FB   = 10'b0000001000,
    S_INIT = 10'b0000010000,
    S_MA   = 10'b0000100000,
    S_MB   = 10'b0001000000,
    S_MC   = 10'b0010000000,
    S_LEN  = 10'b0100000000,
    S_TAIL = 10'b1000000000
  } state_t;

  state_t      state, state_next;
  logic [1:0]  idx, idx_next;
  logic [1:0]  ph, ph_next;     // sub-step within tail/avalanche
  logic [2:0]  pos, pos_next;   // byte position
  logic        fin, fin_next;   // folding the last word
  logic        outv, outv_next;

  // tail stage: 0 pending words, 1 last word, 2 avalanche
  logic [2:0]  stg, stg_next;

  assign in_ready  = (state == S_IDLE) && !outv;
  assign out_valid = outv;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx <= '0;
      ph  <= '0;
      pos <= '0;
      fin <= 1'b0;
      outv <= 1'b0;
      stg <= '0;
    end else begin
      state <= state_next;
      idx <= idx_next;
      ph  <= ph_next;
      pos <= pos_next;
      fin <= fin_next;
      outv <= outv_next;
      stg <= stg_next;
    end
  end

  // Multiply ops are held until the datapath flags mdone.
  always_comb begin
    state_next = state;
    idx_next = idx;
    ph_next = ph;
    pos_next = pos;
    fin_next = fin;
    stg_next = stg;
    outv_next = outv && !out_ready;
    cmd = '{op: xxh_pkg::OP_NONE, idx: idx, tk: xxh_pkg::TK_WORD, pos: pos, tsrc: 1'b0};
    case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.op = xxh_pkg::OP_CAPTURE;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        if (sts.n == 4'd8 && sts.pend == 2'd3) begin
          idx_next = '0;
          fin_next = sts.last;
          state_next = S_FA;
        end else if (!sts.last) begin
          cmd.op = xxh_pkg::OP_PUSH;
          state_next = S_IDLE;
        end else begin
          fin_next = 1'b0;
          state_next = S_INIT;
        end
      end
      S_FA: begin
        cmd.op = xxh_pkg::OP_FOLD_A;
        if (sts.mdone) state_next = S_FB;
      end
      S_FB: begin
        cmd.op = xxh_pkg::OP_FOLD_B;
        if (sts.mdone) begin
          idx_next = idx + 2'd1;
          if (idx != 2'd3) state_next = S_FA;
          else if (fin) state_next = S_INIT;
          else state_next = S_IDLE;
        end
      end
      S_INIT: begin
        cmd.op = xxh_pkg::OP_INIT;
        idx_next = '0;
        state_next = sts.seen ? S_MA : S_LEN;
      end
      S_MA: begin
        cmd.op = xxh_pkg::OP_MRG_A;
        if (sts.mdone) state_next = S_MB;
      end
      S_MB: begin
        cmd.op = xxh_pkg::OP_MRG_B;
        if (sts.mdone) state_next = S_MC;
      end
      S_MC: begin
        cmd.op = xxh_pkg::OP_MRG_C;
        if (sts.mdone) begin
          idx_next = idx + 2'd1;
          state_next = (idx == 2'd3) ? S_LEN : S_MA;
        end
      end
      S_LEN: begin
        cmd.op = xxh_pkg::OP_LEN;
        idx_next = '0;
        ph_next = '0;
        pos_next = '0;
        stg_next = '0;
        state_next = S_TAIL;
      end
      S_TAIL: begin
        case (stg)
          3'd0: begin
            // pending full words
            if (idx >= sts.pend) begin
              stg_next = 3'd1;
              pos_next = '0;
            end else begin
              cmd.tk = xxh_pkg::TK_WORD;
              cmd.tsrc = 1'b0;
              cmd.op = (ph == 2'd0) ? xxh_pkg::OP_T_A :
                       (ph == 2'd1) ? xxh_pkg::OP_T_B : xxh_pkg::OP_T_C;
              if (sts.mdone) begin
                ph_next = (ph == 2'd2) ? 2'd0 : ph + 2'd1;
                if (ph == 2'd2) idx_next = idx + 2'd1;
              end
            end
          end
          3'd1: begin
            // captured last word, unless it was folded
            cmd.tsrc = 1'b1;
            if (fin || {1'b0, pos} >= sts.n) begin
              stg_next = 3'd2;
              ph_next = '0;
            end else if (sts.n == 4'd8) begin
              cmd.tk = xxh_pkg::TK_WORD;
              cmd.op = (ph == 2'd0) ? xxh_pkg::OP_T_A :
                       (ph == 2'd1) ? xxh_pkg::OP_T_B : xxh_pkg::OP_T_C;
              if (sts.mdone) begin
                ph_next = (ph == 2'd2) ? 2'd0 : ph + 2'd1;
                if (ph == 2'd2) pos_next = 3'd7;
                if (ph == 2'd2) stg_next = 3'd2;
              end
            end else if (pos == 3'd0 && sts.n >= 4'd4) begin
              cmd.tk = xxh_pkg::TK_HALF;
              cmd.op = (ph == 2'd0) ? xxh_pkg::OP_T_A : xxh_pkg::OP_T_B;
              if (sts.mdone) begin
                ph_next = (ph == 2'd1) ? 2'd0 : 2'd1;
                if (ph == 2'd1) pos_next = 3'd4;
              end
            end else begin
              cmd.tk = xxh_pkg::TK_BYTE;
              cmd.op = (ph == 2'd0) ? xxh_pkg::OP_T_A : xxh_pkg::OP_T_B;
              if (sts.mdone) begin
                ph_next = (ph == 2'd1) ? 2'd0 : 2'd1;
                if (ph == 2'd1) pos_next = pos + 3'd1;
              end
            end
          end
          default: begin
            cmd.op = (ph == 2'd0) ? xxh_pkg::OP_AV_A :
                     (ph == 2'd1) ? xxh_pkg::OP_AV_B : xxh_pkg::OP_AV_C;
            if (ph == 2'd2) begin
              outv_next = 1'b1;
              fin_next = 1'b0;
              state_next = S_IDLE;
            end else if (sts.mdone) begin
              ph_next = ph + 2'd1;
            end
          end
        endcase
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

### hw/rtl/xxh_checker.sv
// Port-level checker for the XXH64 stream hasher, bound to the top level.
`include "assert_macros.svh"
module xxh_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] hash_value
);
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(hash_value))
  `ASSERT_IMPL(a_no_in_while_out, clk, rst, out_valid, !in_ready)
  `ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready)
endmodule

bind xxhash64_stream_hasher xxh_checker u_chk (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (word_in.valid),
  .in_ready   (word_in.ready),
  .out_valid  (hash_out.valid),
  .out_ready  (hash_out.ready),
  .hash_value (hash_out.hash_value)
);

### verif/tb_pkg.sv
// Scoreboard class: XXH64 digest predictor and queue of expected digests.
package tb_pkg;

  class digest_board;
    logic [63:0] seed;
    logic [63:0] lanes [4];
    logic [63:0] held [3];
    int unsigned held_n;
    logic [63:0] msg_len;
    bit          striped;
    logic [63:0] due_q [$];
    int unsigned errors;

    function new();
      seed = 0;
      held_n = 0;
      msg_len = 0;
      striped = 0;
      errors = 0;
    endfunction

    function logic [63:0] rot(logic [63:0] x, int r);
      return (x << r) | (x >> (64 - r));
    endfunction

    function logic [63:0] lane_mix(logic [63:0] acc, logic [63:0] w);
      logic [63:0] a;
      a = acc + w * xxh_pkg::PR2;
      return rot(a, 31) * xxh_pkg::PR1;
    endfunction

    function logic [63:0] tail8(logic [63:0] h, logic [63:0] w);
      logic [63:0] x;
      x = h ^ lane_mix(64'd0, w);
      return rot(x, 27) * xxh_pkg::PR1 + xxh_pkg::PR4;
    endfunction

    function logic [63:0] digest(logic [63:0] w, int unsigned n, bit took);
      logic [63:0] h;
      int unsigned p;
      if (striped) begin
        h = rot(lanes[0], 1) + rot(lanes[1], 7) + rot(lanes[2], 12) + rot(lanes[3], 18);
        for (int i = 0; i < 4; i++) begin
          h ^= lane_mix(64'd0, lanes[i]);
          h = h * xxh_pkg::PR1 + xxh_pkg::PR4;
        end
      end else begin
        h = seed + xxh_pkg::PR5;
      end
      h += msg_len;
      for (int i = 0; i < held_n; i++) h = tail8(h, held[i]);
      if (!took) begin
        if (n == 8) begin
          h = tail8(h, w);
        end else begin
          p = 0;
          if (n >= 4) begin
            h ^= {32'd0, w[31:0]} * xxh_pkg::PR1;
            h = rot(h, 23) * xxh_pkg::PR2 + xxh_pkg::PR3;
            p = 4;
          end
          for (; p < n; p++) begin
            h ^= {56'd0, w[8*p +: 8]} * xxh_pkg::PR5;
            h = rot(h, 11) * xxh_pkg::PR1;
          end
        end
      end
      h ^= h >> 33;
      h *= xxh_pkg::PR2;
      h ^= h >> 29;
      h *= xxh_pkg::PR3;
      h ^= h >> 32;
      return h;
    endfunction

    // Note one accepted word transfer.
    function void note_word(logic [63:0] w, logic [3:0] cnt, bit last);
      int unsigned n;
      bit took;
      took = 0;
      n = (cnt > 8 || !last) ? 8 : cnt;
      msg_len += n;
      if (n == 8) begin
        if (held_n >= 3) begin
          if (!striped) begin
            lanes[0] = seed + xxh_pkg::PR1 + xxh_pkg::PR2;
            lanes[1] = seed + xxh_pkg::PR2;
            lanes[2] = seed;
            lanes[3] = seed - xxh_pkg::PR1;
            striped = 1;
          end
          for (int i = 0; i < 3; i++) lanes[i] = lane_mix(lanes[i], held[i]);
          lanes[3] = lane_mix(lanes[3], w);
          held_n = 0;
          took = 1;
        end else if (!last) begin
          held[held_n] = w;
          held_n++;
        end
      end
      if (last) begin
        due_q.insert(due_q.size(), digest(w, n, took));
        held_n = 0;
        msg_len = 0;
        striped = 0;
      end
    endfunction

    // Check one accepted digest transfer.
    function void check_digest(logic [63:0] got);
      logic [63:0] want;
      if (due_q.size() == 0) begin
        $display("%0t: unexpected digest %h", $time, got);
        errors++;
        return;
      end
      want = due_q.pop_front();
      if (got !== want) begin
        $display("%0t: hash_value expected %h actual %h", $time, want, got);
        errors++;
      end
    endfunction
  endclass
endpackage

### verif/tb_top.sv
// Testbench top: drives the XXH64 stream hasher and checks every digest.
module tb_top;

  logic clk;
  logic rst;
  xxh_word_if word_ch ();
  xxh_hash_if hash_ch ();
  xxh_cfg_if  seed_ch ();

  tb_pkg::digest_board board;
  int unsigned cycles = 0;
  bit          rx_hold;  // receiver stall pattern select

  xxhash64_stream_hasher DUT (
    .clk      (clk),
    .rst      (rst),
    .word_in  (word_ch.sink),
    .hash_out (hash_ch.source),
    .seed_cfg (seed_ch.sink)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Watchdog: ends the run with an error report if the bench hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 1000000) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // Receiver: stall pattern alternates between heavy and occasional stalls.
  always @(posedge clk) begin
    if (rst) begin
      hash_ch.ready <= 1'b0;
    end else if (rx_hold) begin
      hash_ch.ready <= ($urandom_range(0, 3) == 0);
    end else begin
      hash_ch.ready <= ($urandom_range(0, 9) != 0);
    end
  end

  // Digest monitor: a transfer is valid & ready at the rising edge.
  always @(posedge clk) begin
    if (!rst && hash_ch.valid && hash_ch.ready) board.check_digest(hash_ch.hash_value);
  end

  // Drive one word and hold it until the transfer happens.
  task automatic send_word(logic [63:0] w, logic [3:0] cnt, bit last);
    word_ch.valid      <= 1'b1;
    word_ch.data_word  <= w;
    word_ch.byte_count <= cnt;
    word_ch.last_word  <= last;
    do @(posedge clk); while (!word_ch.ready);
    board.note_word(w, cnt, last);
  endtask

  task automatic pause_sender();
    word_ch.valid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk);
  endtask

  // Random data, with some all-zero and all-one words to hit the extremes.
  function automatic logic [63:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 64'd0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // One message of nwords; burst state shared through burst_left.
  int unsigned burst_left;
  task automatic send_message(int unsigned nwords, logic [3:0] last_cnt);
    for (int i = 0; i < nwords; i++) begin
      if (burst_left == 0) begin
        if ($urandom_range(0, 2) != 0) pause_sender();
        burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      // non-final words sometimes carry a short count, which must be ignored
      send_word(pick_word(),
                (i == nwords - 1) ? last_cnt
                  : (($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15)) : 4'd8),
                i == nwords - 1);
    end
  endtask

  // Seed writes only when idle: drain digests, then let the tail finish.
  task automatic write_seed(logic [63:0] s);
    word_ch.valid <= 1'b0;
    while (board.due_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    seed_ch.valid     <= 1'b1;
    seed_ch.hash_seed <= s;
    do @(posedge clk); while (!seed_ch.ready);
    board.seed = s;
    seed_ch.valid <= 1'b0;
  endtask

  int unsigned sent;
  int unsigned nw;

  initial begin
    board = new();
    rx_hold = 0;
    burst_left = 0;
    rst = 1'b1;
    word_ch.valid <= 1'b0;
    word_ch.data_word <= '0;
    word_ch.byte_count <= '0;
    word_ch.last_word <= 1'b0;
    seed_ch.valid <= 1'b0;
    seed_ch.hash_seed <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty message, every final byte count, saturating counts,
    // stripe boundaries, under reset seed and extreme seeds.
    send_word(64'h0123456789abcdef, 4'd0, 1'b1);
    for (int c = 1; c <= 15; c++) send_word('1, 4'(c), 1'b1);
    send_message(4, 4'd8);   // exactly one stripe, last word folds it
    send_message(4, 4'd3);   // partial word after three held words
    send_message(5, 4'd0);   // stripe then empty final word
    write_seed('1);
    send_message(2, 4'd5);
    send_message(9, 4'd7);
    write_seed(64'h8000000000000001);
    send_message(3, 4'd4);

    // Random: mostly short messages, a few long ones, seed changes between phases.
    sent = 0;
    for (int ph = 0; ph < 4; ph++) begin
      rx_hold = ph[0];
      write_seed(ph == 3 ? 64'd0 : {$urandom, $urandom});
      while (sent < 228 * (ph + 1)) begin
        nw = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 10);
        send_message(nw, 4'($urandom_range(0, 8)));
        sent += nw;
      end
    end
    word_ch.valid <= 1'b0;

    while (board.due_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (board.errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end
endmodule
